FILE: design/lzss_pkg.sv
// Shared constants for the LZSS stream decompressor.
`timescale 1ns / 1ps
`default_nettype none
package lzss_pkg;
	localparam int STORE_DEPTH = 8192;
	localparam int MIN_LEN     = 3;
	localparam int BYTE_W      = 8;
	localparam int CNT_W       = 32;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int POS_W       = 13;
	localparam int LEN_W       = 5;
	localparam logic [CNT_W-1:0] LIMIT_RESET = '1;
endpackage
`default_nettype wire

FILE: design/lzss_if.sv
// Valid/ready channel interfaces for compressed input and decompressed output.
`timescale 1ns / 1ps
`default_nettype none
interface lzss_in_if;
	logic                       valid;
	logic                       ready;
	logic [lzss_pkg::BYTE_W-1:0] in_byte;
	logic                       stream_start;
	logic                       stream_end;
	modport source (output valid, output in_byte, output stream_start, output stream_end,
		input ready);
	modport sink (input valid, input in_byte, input stream_start, input stream_end,
		output ready);
endinterface

interface lzss_out_if;
	logic                       valid;
	logic                       ready;
	logic [lzss_pkg::BYTE_W-1:0] out_byte;
	logic                       run_end;
	logic                       limit_hit;
	modport source (output valid, output out_byte, output run_end, output limit_hit,
		input ready);
	modport sink (input valid, input out_byte, input run_end, input limit_hit,
		output ready);
endinterface
`default_nettype wire

FILE: design/lzss_ram.sv
// Simple dual-port RAM, one write and one registered read port, read-first.
`timescale 1ns / 1ps
`default_nettype none
module lzss_ram #(
	parameter int DEPTH = 8192,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: design/lzss_stream_decompressor.sv
// Top level: token decoder, match copy sequencer and history store.
// An accepted input word is registered into the decoder state; its result bytes are then
// registered into the output register, which holds while the output is stalled. Input is
// accepted only while idle, and a match copy reads the history once per output byte.
// Reset clears counters and flags and sets the limit to all ones; the history store is
// not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module lzss_stream_decompressor (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [lzss_pkg::CNT_W-1:0] cfg_wdata,
	lzss_in_if.sink                        in_ch,
	lzss_out_if.source                     out_ch
);
	import lzss_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_LIT, ST_MATCH} state_t;

	state_t             st_q;
	logic [CNT_W-1:0]   limit_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BYTE_W-1:0]  flags_q;
	logic [3:0]         bidx_q;
	logic [BYTE_W-1:0]  mfb_q;
	logic               await_q;
	logic               stop_q;
	logic [LEN_W-1:0]   rem_q;
	logic [BYTE_W-1:0]  lit_q;
	logic               ov_q;
	logic [BYTE_W-1:0]  obyte_q;
	logic               orun_q;
	logic               ohit_q;

	logic [POS_W-1:0]   pos_s1;
	logic               hit_s1;
	logic [BYTE_W-1:0]  fwd_s1;

	logic               acc;
	logic               eff_stop, eff_await;
	logic [3:0]         eff_bidx;
	logic [BYTE_W-1:0]  eff_flags, eff_mfb;
	logic [CNT_W-1:0]   eff_cnt;
	logic               no_room;
	logic [POS_W-1:0]   offset_in;
	logic [LEN_W-1:0]   len_in;
	logic               can_emit, emit, lim_now, last;
	logic [BYTE_W-1:0]  emit_val, rdata;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;

	assign in_ch.ready = (st_q == ST_IDLE);
	assign acc         = in_ch.valid && in_ch.ready;

	assign eff_stop  = in_ch.stream_start ? 1'b0 : stop_q;
	assign eff_await = in_ch.stream_start ? 1'b0 : await_q;
	assign eff_bidx  = in_ch.stream_start ? 4'd8 : bidx_q;
	assign eff_flags = in_ch.stream_start ? '0 : flags_q;
	assign eff_mfb   = in_ch.stream_start ? '0 : mfb_q;
	assign eff_cnt   = in_ch.stream_start ? '0 : cnt_q;
	assign no_room   = eff_cnt >= limit_q;
	assign offset_in = POS_W'({eff_mfb[7:4], in_ch.in_byte});
	assign len_in    = LEN_W'(eff_mfb[3:0]) + LEN_W'(MIN_LEN);

	assign can_emit = !ov_q || out_ch.ready;
	assign emit     = (st_q != ST_IDLE) && can_emit;
	assign lim_now  = (cnt_q + CNT_W'(1)) == limit_q;
	assign last     = (st_q == ST_LIT) || (rem_q == '0) || lim_now;

	always_comb begin
		if (st_q == ST_LIT) begin
			emit_val = lit_q;
		end else if (CNT_W'(pos_s1) < cnt_q) begin
			emit_val = hit_s1 ? fwd_s1 : rdata;
		end else begin
			emit_val = '0;
		end
	end

	assign wr_en   = emit && (cnt_q < CNT_W'(STORE_DEPTH));
	assign wr_addr = cnt_q[ADDR_W-1:0];

	always_comb begin
		if (st_q == ST_IDLE) begin
			rd_addr = ADDR_W'(offset_in);
		end else if (emit) begin
			rd_addr = ADDR_W'(pos_s1 + POS_W'(1));
		end else begin
			rd_addr = ADDR_W'(pos_s1);
		end
	end

	lzss_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (BYTE_W)
	) u_hist (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (emit_val),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// Forward a byte written in the same cycle as the read of its address.
	always_ff @(posedge clk) begin
		hit_s1 <= wr_en && (wr_addr == rd_addr);
		fwd_s1 <= emit_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			limit_q <= LIMIT_RESET;
			cnt_q   <= '0;
			flags_q <= '0;
			bidx_q  <= 4'd8;
			mfb_q   <= '0;
			await_q <= 1'b0;
			stop_q  <= 1'b0;
			rem_q   <= '0;
			lit_q   <= '0;
			pos_s1  <= '0;
			ov_q    <= 1'b0;
			obyte_q <= '0;
			orun_q  <= 1'b0;
			ohit_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (acc) begin
				cnt_q <= eff_cnt;
				if (!eff_stop) begin
					if (eff_bidx[3]) begin
						flags_q <= in_ch.in_byte;
						bidx_q  <= '0;
						mfb_q   <= eff_mfb;
						await_q <= eff_await;
						stop_q  <= in_ch.stream_end;
					end else if (eff_await) begin
						flags_q <= eff_flags;
						bidx_q  <= eff_bidx + 4'd1;
						mfb_q   <= eff_mfb;
						await_q <= 1'b0;
						stop_q  <= no_room || in_ch.stream_end;
						if (!no_room) begin
							st_q   <= ST_MATCH;
							rem_q  <= len_in - LEN_W'(1);
							pos_s1 <= offset_in;
						end
					end else if (eff_flags[eff_bidx[2:0]]) begin
						flags_q <= eff_flags;
						bidx_q  <= eff_bidx;
						mfb_q   <= in_ch.in_byte;
						await_q <= 1'b1;
						stop_q  <= in_ch.stream_end;
					end else begin
						flags_q <= eff_flags;
						bidx_q  <= eff_bidx + 4'd1;
						mfb_q   <= eff_mfb;
						await_q <= eff_await;
						stop_q  <= no_room || in_ch.stream_end;
						if (!no_room) begin
							st_q  <= ST_LIT;
							lit_q <= in_ch.in_byte;
						end
					end
				end
			end else if (emit) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (lim_now) begin
					stop_q <= 1'b1;
				end
				if (last) begin
					st_q <= ST_IDLE;
				end else begin
					rem_q  <= rem_q - LEN_W'(1);
					pos_s1 <= pos_s1 + POS_W'(1);
				end
			end
			if (emit) begin
				ov_q    <= 1'b1;
				obyte_q <= emit_val;
				orun_q  <= last;
				ohit_q  <= lim_now;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid     = ov_q;
	assign out_ch.out_byte  = obyte_q;
	assign out_ch.run_end   = orun_q;
	assign out_ch.limit_hit = ohit_q;

	a_emit_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (cnt_q < limit_q))
		else $error("byte produced at or past the output limit");

	a_fwd_is_last_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MATCH && hit_s1) |-> ((CNT_W'(pos_s1) + CNT_W'(1)) == cnt_q))
		else $error("forwarded byte does not match the newest history entry");

	a_match_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && st_q == ST_MATCH && rem_q == '0) |=> (st_q == ST_IDLE))
		else $error("match copy ran past its length");

	a_hit_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && ohit_q) |-> orun_q)
		else $error("limit reached without closing the run");

	a_hit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && lim_now) |=> stop_q)
		else $error("limit reached without stopping");
endmodule
`default_nettype wire

FILE: bench/tb_lzss_stream_decompressor.sv
// Self-checking bench for the LZSS stream decompressor: directed table, then random streams.
`timescale 1ns / 1ps
module tb_lzss_stream_decompressor;
	import lzss_pkg::*;

	localparam int WATCHDOG    = 4000;
	localparam int SETTLE      = 30;
	localparam int PHASE_WORDS = 30;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              lim;
	} out_word_t;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {FLOW, LIGHT, HALF, HEAVY} stall_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [BYTE_W-1:0] data;
		logic              first;
		logic              last;
		logic              known;
		logic [4:0]        n;
		logic [BYTE_W-1:0] val;
		logic              lim;
		logic [CNT_W-1:0]  limit;
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	lzss_in_if  in_ch();
	lzss_out_if out_ch();

	lzss_stream_decompressor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// decoder state
	logic [BYTE_W-1:0] hist [STORE_DEPTH];
	logic [CNT_W-1:0]  out_cnt;
	logic [CNT_W-1:0]  limit_r;
	logic [7:0]        flags;
	logic [3:0]        bit_idx;
	logic [7:0]        first_b;
	logic              await2;
	logic              halted;
	out_word_t         decoded_now [$];
	out_word_t         pending_bytes [$];

	// random stream state
	logic       gs_active;
	int         gs_left;
	logic [3:0] gs_bit;
	logic [7:0] gs_flag;
	logic       gs_pend;
	logic [7:0] gs_b1;
	int         gs_len;
	int         gs_est;

	int     burst_left;
	int     sent_words;
	int     cfg_writes;
	int     checked;
	int     lim_seen;
	int     mismatches;
	int     idle_cycles;
	int     stall_left;
	stall_t stall_mode;
	row_t   plan [0:30];

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic row_t word_row(input logic [7:0] d, input logic f, input logic l,
		input logic k, input int n, input logic [7:0] v, input logic lim);
		return '{ROW_WORD, d, f, l, k, 5'(n), v, lim, '0};
	endfunction

	function automatic row_t cfg_row(input logic [CNT_W-1:0] v);
		return '{ROW_CFG, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, v};
	endfunction

	function automatic bit put_byte(input logic [BYTE_W-1:0] v);
		if (halted || out_cnt >= limit_r) begin
			halted = 1'b1;
			return 1'b0;
		end
		if (out_cnt < STORE_DEPTH)
			hist[out_cnt[ADDR_W-1:0]] = v;
		out_cnt++;
		if (out_cnt >= limit_r)
			halted = 1'b1;
		decoded_now.push_back('{data: v, last: 1'b0, lim: halted});
		return 1'b1;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic s, input logic e);
		logic [11:0]      off;
		int               len;
		logic [CNT_W-1:0] pos;
		logic [7:0]       v;
		decoded_now.delete();
		if (s) begin
			out_cnt = '0;
			flags = '0;
			bit_idx = 4'd8;
			first_b = '0;
			await2 = 1'b0;
			halted = 1'b0;
		end
		if (!halted) begin
			if (bit_idx >= 4'd8) begin
				flags = b;
				bit_idx = '0;
			end else if (await2) begin
				off = {first_b[7:4], b};
				len = int'(first_b[3:0]) + MIN_LEN;
				await2 = 1'b0;
				bit_idx++;
				for (int k = 0; k < len; k++) begin
					pos = CNT_W'(off) + CNT_W'(k);
					v = (pos < out_cnt && pos < STORE_DEPTH) ? hist[pos[ADDR_W-1:0]] : '0;
					if (!put_byte(v) || halted)
						break;
				end
			end else if (flags[bit_idx[2:0]]) begin
				first_b = b;
				await2 = 1'b1;
			end else begin
				bit_idx++;
				void'(put_byte(b));
			end
			if (e)
				halted = 1'b1;
		end
		if (decoded_now.size() > 0)
			decoded_now[$].last = 1'b1;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic s, input logic e,
		input logic known, input int n, input logic [7:0] val, input logic lim);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid        <= 1'b1;
		in_ch.in_byte      <= b;
		in_ch.stream_start <= s;
		in_ch.stream_end   <= e;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sent_words++;
		decode_byte(b, s, e);
		if (known) begin
			for (int i = 0; i < n; i++)
				pending_bytes.push_back('{data: val, last: 1'(i == n - 1),
					lim: lim && (i == n - 1)});
		end else begin
			foreach (decoded_now[i])
				pending_bytes.push_back(decoded_now[i]);
		end
	endtask

	task automatic write_limit(input logic [CNT_W-1:0] v);
		in_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		limit_r = v;
		cfg_writes++;
		burst_left = 0;
	endtask

	task automatic next_random_byte(output logic [7:0] b, output logic s, output logic e,
		output bit counted);
		int          span;
		int          pick;
		logic [11:0] off;
		counted = 1'b1;
		s = 1'b0;
		e = 1'b0;
		if (!gs_active && $urandom_range(0, 9) == 0) begin
			b = 8'($urandom);
			e = 1'($urandom_range(0, 1));
			counted = 1'b0;
			return;
		end
		if (!gs_active) begin
			gs_active = 1'b1;
			gs_left = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, 60);
			s = 1'b1;
		end else begin
			s = ($urandom_range(0, 39) == 0);
		end
		if (s) begin
			gs_bit = 4'd8;
			gs_pend = 1'b0;
			gs_est = 0;
		end
		if (gs_bit == 4'd8) begin
			b = 8'($urandom);
			gs_flag = b;
			gs_bit = '0;
		end else if (gs_pend) begin
			b = gs_b1;
			gs_pend = 1'b0;
			gs_bit++;
			gs_est += gs_len;
		end else if (gs_flag[gs_bit[2:0]]) begin
			pick = $urandom_range(0, 9);
			if (pick < 6 && gs_est > 0) begin
				span = (gs_est > 64) ? 64 : gs_est;
				off = 12'(gs_est - 1 - int'($urandom_range(0, span - 1)));
			end else if (pick < 8) begin
				off = 12'(gs_est + int'($urandom_range(0, 20)));
			end else begin
				off = 12'($urandom_range(0, 4095));
			end
			b = {off[11:8], 4'($urandom)};
			gs_len = int'(b[3:0]) + MIN_LEN;
			gs_b1 = off[7:0];
			gs_pend = 1'b1;
		end else begin
			b = 8'($urandom);
			gs_bit++;
			gs_est++;
		end
		gs_left--;
		if (gs_left == 0) begin
			e = 1'b1;
			gs_active = 1'b0;
		end
	endtask

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				stall_mode = stall_t'($urandom_range(0, 3));
				stall_left = $urandom_range(16, 96);
			end
			stall_left--;
			case (stall_mode)
				FLOW:    out_ch.ready <= 1'b1;
				LIGHT:   out_ch.ready <= ($urandom_range(0, 3) != 0);
				HALF:    out_ch.ready <= 1'($urandom_range(0, 1));
				default: out_ch.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_bytes.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected word: byte %h run_end %b limit_hit %b",
						out_ch.out_byte, out_ch.run_end, out_ch.limit_hit);
				mismatches++;
			end else begin
				want = pending_bytes.pop_front();
				checked++;
				if (out_ch.limit_hit === 1'b1)
					lim_seen++;
				if (out_ch.out_byte !== want.data || out_ch.run_end !== want.last ||
					out_ch.limit_hit !== want.lim) begin
					if (mismatches < 10)
						$display("word %0d: expected %h/%b/%b, got %h/%b/%b", checked,
							want.data, want.last, want.lim,
							out_ch.out_byte, out_ch.run_end, out_ch.limit_hit);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
			(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [7:0]       b;
		logic             s;
		logic             e;
		bit               counted;
		int               phase_words;
		logic [CNT_W-1:0] limits [8];
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.in_byte      <= '0;
		in_ch.stream_start <= 1'b0;
		in_ch.stream_end   <= 1'b0;
		out_cnt = '0;
		limit_r = LIMIT_RESET;
		flags = '0;
		bit_idx = 4'd8;
		first_b = '0;
		await2 = 1'b0;
		halted = 1'b0;
		gs_active = 1'b0;
		burst_left = 0;

		plan = '{
			word_row(8'hFF, 1'b0, 1'b0, 1'b1, 0, 8'h00, 1'b0),
			word_row(8'h0F, 1'b0, 1'b0, 1'b1, 0, 8'h00, 1'b0),
			word_row(8'h00, 1'b0, 1'b0, 1'b1, 18, 8'h00, 1'b0),
			word_row(8'hF0, 1'b0, 1'b0, 1'b1, 0, 8'h00, 1'b0),
			word_row(8'hFF, 1'b0, 1'b0, 1'b1, 3, 8'h00, 1'b0),
			word_row(8'hA0, 1'b1, 1'b0, 1'b1, 0, 8'h00, 1'b0),
			word_row(8'h00, 1'b0, 1'b0, 1'b1, 1, 8'h00, 1'b0),
			word_row(8'hFF, 1'b0, 1'b0, 1'b1, 1, 8'hFF, 1'b0),
			word_row(8'hA5, 1'b0, 1'b0, 1'b0, 0, 8'h00, 1'b0),
			word_row(8'h5A, 1'b0, 1'b0, 1'b0, 0, 8'h00, 1'b0),
			word_row(8'h3C, 1'b0, 1'b0, 1'b0, 0, 8'h00, 1'b0),
			word_row(8'h02, 1'b0, 1'b0, 1'b1, 0, 8'h00, 1'b0),
			word_row(8'h01, 1'b0, 1'b0, 1'b0, 0, 8'h00, 1'b0),
			word_row(8'h81, 1'b0, 1'b0, 1'b0, 0, 8'h00, 1'b0),
			word_row(8'h00, 1'b0, 1'b1, 1'b1, 0, 8'h00, 1'b0),
			word_row(8'h33, 1'b0, 1'b0, 1'b1, 0, 8'h00, 1'b0),
			word_row(8'h44, 1'b1, 1'b1, 1'b1, 0, 8'h00, 1'b0),
			cfg_row(32'd0),
			word_row(8'h00, 1'b1, 1'b0, 1'b1, 0, 8'h00, 1'b0),
			word_row(8'h55, 1'b0, 1'b0, 1'b1, 0, 8'h00, 1'b0),
			cfg_row(32'd4),
			word_row(8'h01, 1'b1, 1'b0, 1'b1, 0, 8'h00, 1'b0),
			word_row(8'h0F, 1'b0, 1'b0, 1'b1, 0, 8'h00, 1'b0),
			word_row(8'h00, 1'b0, 1'b0, 1'b1, 4, 8'h00, 1'b1),
			word_row(8'h66, 1'b0, 1'b0, 1'b1, 0, 8'h00, 1'b0),
			cfg_row(LIMIT_RESET),
			word_row(8'h00, 1'b1, 1'b0, 1'b1, 0, 8'h00, 1'b0),
			word_row(8'h77, 1'b0, 1'b0, 1'b1, 1, 8'h77, 1'b0),
			word_row(8'h88, 1'b0, 1'b0, 1'b1, 1, 8'h88, 1'b0),
			cfg_row(32'd1),
			word_row(8'h99, 1'b0, 1'b0, 1'b1, 0, 8'h00, 1'b0)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_limit(plan[i].limit);
			else
				send_byte(plan[i].data, plan[i].first, plan[i].last, plan[i].known,
					int'(plan[i].n), plan[i].val, plan[i].lim);
		end

		limits = '{LIMIT_RESET, 32'd0, 32'd1, 32'd60, CNT_W'($urandom_range(2, 300)),
			32'hFFFF_FFFE, 32'h8000_0000, 32'd150};
		foreach (limits[p]) begin
			write_limit(limits[p]);
			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				next_random_byte(b, s, e, counted);
				send_byte(b, s, e, 1'b0, 0, 8'h00, 1'b0);
				if (counted)
					phase_words++;
			end
		end

		// drain
		in_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("summary: %0d compressed words sent over %0d limit settings", sent_words,
			cfg_writes);
		$display("summary: %0d output words checked, %0d with limit flag, %0d mismatches",
			checked, lim_seen, mismatches);
		if (mismatches == 0 && pending_bytes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
